[rtl/received_block_range_tracker_defines.svh]
// Assertion macros shared by the range tracker RTL.
`ifndef RECEIVED_BLOCK_RANGE_TRACKER_DEFINES_SVH
`define RECEIVED_BLOCK_RANGE_TRACKER_DEFINES_SVH

// A property checked on every clock edge outside reset.
`define RBRT_ASSERT_RST(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// A condition that must never hold outside reset.
`define RBRT_ASSERT_NEVER(label, expr, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) !(expr)) else $error(msg);

`endif

[rtl/rbrt_pkg.sv]
// Types and constants of the received block range tracker.
`default_nettype none

package rbrt_pkg;

    localparam int IDX_W  = 12;
    localparam int CNT_W  = 13;
    localparam int LIM_W  = 6;
    localparam int OP_W   = 2;
    localparam int WORD_W = 32;
    localparam int OFS_W  = 5;

    typedef logic [OP_W-1:0]  t_op;
    typedef logic [IDX_W-1:0] t_index;
    typedef logic [CNT_W-1:0] t_count;
    typedef logic [LIM_W-1:0] t_limit;
    typedef logic [WORD_W-1:0] t_word;

    localparam t_op OP_MARK   = 2'd0;
    localparam t_op OP_SETPOS = 2'd1;
    localparam t_op OP_SCAN   = 2'd2;
    localparam t_op OP_NONE   = 2'd3;

    localparam t_limit MAX_REPORTS     = 6'd63;
    localparam t_count BLOCK_COUNT_RST = 13'd4096;

endpackage

`default_nettype wire

[rtl/rbrt_intf.sv]
// Handshake interfaces for the request and result channels of the range tracker.
`default_nettype none

interface rbrt_in_if;
    logic                  valid;
    logic                  ready;
    rbrt_pkg::t_op         op;
    rbrt_pkg::t_index      blk_idx;
    rbrt_pkg::t_limit      request_limit;

    modport source (output valid, output op, output blk_idx, output request_limit,
                    input ready);
    modport sink   (input valid, input op, input blk_idx, input request_limit,
                    output ready);
endinterface

interface rbrt_out_if;
    logic                  valid;
    logic                  ready;
    logic                  status;
    logic                  newly_marked;
    logic                  has_range;
    rbrt_pkg::t_index      range_start;
    rbrt_pkg::t_count      range_length;
    rbrt_pkg::t_count      received_total;
    logic                  last;

    modport source (output valid, output status, output newly_marked, output has_range,
                    output range_start, output range_length, output received_total,
                    output last, input ready);
    modport sink   (input valid, input status, input newly_marked, input has_range,
                    input range_start, input range_length, input received_total,
                    input last, output ready);
endinterface

`default_nettype wire

[rtl/received_block_range_tracker.sv]
// Received block range tracker: bitmap of received blocks with a run-reporting scan.
`default_nettype none

// The tracker keeps one received bit per block in a memory of 32-bit words, together
// with a scan position and the count found by the last scan. A mark transaction sets
// the bit of one block and reports whether it was clear before; it reads the word, then
// writes it back and loads the result, and the write-back waits while the output
// register is still occupied. A set-position transaction moves the scan start and,
// like any index error or the unused operation code, answers with the same timing.
// A scan walks every block in use, circularly from the scan position, reporting up
// to request_limit runs of received blocks as one result transaction each and
// finishing with one transaction that carries the count. The walk is done by one
// step unit working on the registered bitmap word: each cycle it consumes the whole
// stretch of equal bits that starts at the current block, up to the end of the word,
// the end of the blocks in use or the scan start, whichever comes first. A result
// that cannot leave because the output register is still occupied stalls the walk.
// After reset the bitmap is cleared by a pass over all words, one word per cycle,
// during which no request is accepted; configuration writes are taken throughout.
// The block_count register must only be written while the tracker is idle.
module received_block_range_tracker #(
    parameter int MAX_BLOCKS = 4096
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_cfg_we,
    input  wire rbrt_pkg::t_count   i_cfg_wdata,
    rbrt_in_if.sink                 i_in,
    rbrt_out_if.source              o_out
);

`include "received_block_range_tracker_defines.svh"

    localparam int CW     = rbrt_pkg::CNT_W;
    localparam int IW     = rbrt_pkg::IDX_W;
    localparam int WW     = rbrt_pkg::WORD_W;
    localparam int OW     = rbrt_pkg::OFS_W;
    localparam int LW     = OW + 1;
    localparam int WORDS  = (MAX_BLOCKS + WW - 1) / WW;
    localparam int AW     = (WORDS > 1) ? $clog2(WORDS) : 1;
    localparam int CAP    = (MAX_BLOCKS > (2 ** CW) - 1) ? (2 ** CW) - 1 : MAX_BLOCKS;

    localparam logic [2:0] ST_CLEAR = 3'd0;
    localparam logic [2:0] ST_IDLE  = 3'd1;
    localparam logic [2:0] ST_RESP  = 3'd2;
    localparam logic [2:0] ST_MARK  = 3'd3;
    localparam logic [2:0] ST_SCAN  = 3'd4;
    localparam logic [2:0] ST_FINAL = 3'd5;

    // Word address of a block index.
    function automatic logic [AW-1:0] word_addr(input logic [CW-1:0] idx);
        logic [CW+AW-1:0] ext;
        ext = {{AW{1'b0}}, idx};
        return ext[AW+OW-1:OW];
    endfunction

    // Bitmap storage.
    rbrt_pkg::t_word    mem [WORDS];
    rbrt_pkg::t_word    r_word;
    logic               mem_we;
    logic [AW-1:0]      mem_waddr;
    rbrt_pkg::t_word    mem_wdata;
    logic [AW-1:0]      rd_addr;

    // Control state.
    logic [2:0]         r_state, n_state;
    logic [AW-1:0]      r_clr_addr, n_clr_addr;
    rbrt_pkg::t_count   r_block_count;
    rbrt_pkg::t_index   r_pos, n_pos;
    rbrt_pkg::t_count   r_done, n_done;
    logic [CW-1:0]      r_idx, n_idx;
    logic [CW-1:0]      r_begin, n_begin;
    rbrt_pkg::t_count   r_cnt, n_cnt;
    logic [CW-1:0]      r_start, n_start;
    logic               r_open, n_open;
    rbrt_pkg::t_limit   r_lim, n_lim;
    logic               r_status, n_status;

    // Output register.
    logic               r_out_valid, n_out_valid;
    logic               r_out_status, n_out_status;
    logic               r_out_newly, n_out_newly;
    logic               r_out_has_range, n_out_has_range;
    rbrt_pkg::t_index   r_out_start, n_out_start;
    rbrt_pkg::t_count   r_out_length, n_out_length;
    rbrt_pkg::t_count   r_out_total, n_out_total;
    logic               r_out_last, n_out_last;

    // Step unit signals.
    rbrt_pkg::t_count   eff;
    logic               slot_free;
    logic               accept;
    logic [CW:0]        idx_x, eff_x, begin_x, word_end, seg_end, step_end;
    logic [LW-1:0]      seg_len, run_len;
    rbrt_pkg::t_word    seg;
    logic               v;
    logic               hit_wrap, clear_emit, wrap_emit, emit, walk_done;
    logic [CW-1:0]      run_start, step_idx, begin_pick;
    rbrt_pkg::t_count   emit_len;
    logic               mark_bit;

    assign eff = (r_block_count > CW'(CAP)) ? CW'(CAP) : r_block_count;
    assign slot_free = !r_out_valid || o_out.ready;
    assign i_in.ready = (r_state == ST_IDLE);
    assign accept = i_in.valid && i_in.ready;
    assign mark_bit = r_word[r_idx[OW-1:0]];
    assign begin_pick = ({1'b0, r_pos} < eff) ? {1'b0, r_pos} : '0;

    // One walk step: the stretch of equal bits from the current block to the end of
    // its word, the end of the blocks in use, or the scan start, whichever comes first.
    always_comb begin
        idx_x    = {1'b0, r_idx};
        eff_x    = {1'b0, eff};
        begin_x  = {1'b0, r_begin};
        word_end = ({1'b0, r_idx} | (CW+1)'(WW - 1)) + 1'b1;
        seg_end  = (word_end < eff_x) ? word_end : eff_x;
        if (begin_x > idx_x && begin_x < seg_end) begin
            seg_end = begin_x;
        end
        seg_len = LW'(seg_end - idx_x);
        seg     = r_word >> r_idx[OW-1:0];
        v       = seg[0];
        run_len = seg_len;
        for (int i = WW - 1; i >= 0; i--) begin
            if (LW'(i) < seg_len && seg[i] != v) begin
                run_len = LW'(i);
            end
        end
        step_end   = idx_x + (CW+1)'(run_len);
        hit_wrap   = (step_end == eff_x);
        clear_emit = !v && r_open && (r_lim != '0);
        wrap_emit  = hit_wrap && v && (r_lim != '0);
        emit       = clear_emit || wrap_emit;
        run_start  = (v && !r_open) ? r_idx : r_start;
        emit_len   = clear_emit ? (r_idx - r_start) : (eff - run_start);
        step_idx   = hit_wrap ? '0 : step_end[CW-1:0];
        walk_done  = (step_idx == r_begin);
    end

    always_comb begin
        n_state         = r_state;
        n_clr_addr      = r_clr_addr;
        n_pos           = r_pos;
        n_done          = r_done;
        n_idx           = r_idx;
        n_begin         = r_begin;
        n_cnt           = r_cnt;
        n_start         = r_start;
        n_open          = r_open;
        n_lim           = r_lim;
        n_status        = r_status;
        n_out_valid     = r_out_valid && !o_out.ready;
        n_out_status    = r_out_status;
        n_out_newly     = r_out_newly;
        n_out_has_range = r_out_has_range;
        n_out_start     = r_out_start;
        n_out_length    = r_out_length;
        n_out_total     = r_out_total;
        n_out_last      = r_out_last;
        mem_we          = 1'b0;
        mem_waddr       = word_addr(r_idx);
        mem_wdata       = r_word | (rbrt_pkg::t_word'(1) << r_idx[OW-1:0]);

        case (r_state)
            ST_CLEAR: begin
                mem_we    = 1'b1;
                mem_waddr = r_clr_addr;
                mem_wdata = '0;
                if (r_clr_addr == AW'(WORDS - 1)) begin
                    n_state = ST_IDLE;
                end else begin
                    n_clr_addr = r_clr_addr + 1'b1;
                end
            end
            ST_IDLE: begin
                if (accept) begin
                    case (i_in.op)
                        rbrt_pkg::OP_MARK: begin
                            if ({1'b0, i_in.blk_idx} >= eff) begin
                                n_status = 1'b1;
                                n_state  = ST_RESP;
                            end else begin
                                n_idx   = CW'(i_in.blk_idx);
                                n_state = ST_MARK;
                            end
                        end
                        rbrt_pkg::OP_SETPOS: begin
                            if ({1'b0, i_in.blk_idx} >= eff) begin
                                n_status = 1'b1;
                            end else begin
                                n_status = 1'b0;
                                n_pos    = i_in.blk_idx;
                            end
                            n_state = ST_RESP;
                        end
                        rbrt_pkg::OP_SCAN: begin
                            n_lim = (i_in.request_limit > rbrt_pkg::MAX_REPORTS) ?
                                    rbrt_pkg::MAX_REPORTS : i_in.request_limit;
                            if (eff == '0) begin
                                n_state = ST_FINAL;
                            end else begin
                                n_idx   = begin_pick;
                                n_begin = begin_pick;
                                n_cnt   = '0;
                                n_open  = 1'b0;
                                n_state = ST_SCAN;
                            end
                        end
                        default: begin
                            n_status = 1'b0;
                            n_state  = ST_RESP;
                        end
                    endcase
                end
            end
            ST_RESP: begin
                if (slot_free) begin
                    n_out_valid     = 1'b1;
                    n_out_status    = r_status;
                    n_out_newly     = 1'b0;
                    n_out_has_range = 1'b0;
                    n_out_start     = '0;
                    n_out_length    = '0;
                    n_out_total     = '0;
                    n_out_last      = 1'b1;
                    n_state         = ST_IDLE;
                end
            end
            ST_MARK: begin
                if (slot_free) begin
                    mem_we          = 1'b1;
                    n_out_valid     = 1'b1;
                    n_out_status    = 1'b0;
                    n_out_newly     = !mark_bit;
                    n_out_has_range = 1'b0;
                    n_out_start     = '0;
                    n_out_length    = '0;
                    n_out_total     = '0;
                    n_out_last      = 1'b1;
                    n_state         = ST_IDLE;
                end
            end
            ST_SCAN: begin
                if (!emit || slot_free) begin
                    if (v) begin
                        n_cnt = r_cnt + CW'(run_len);
                    end
                    n_start = run_start;
                    n_open  = v ? !wrap_emit : (r_open && !clear_emit);
                    if (emit) begin
                        n_lim           = r_lim - 1'b1;
                        n_pos           = clear_emit ? r_idx[IW-1:0] : '0;
                        n_out_valid     = 1'b1;
                        n_out_status    = 1'b0;
                        n_out_newly     = 1'b0;
                        n_out_has_range = 1'b1;
                        n_out_start     = run_start[IW-1:0];
                        n_out_length    = emit_len;
                        n_out_total     = '0;
                        n_out_last      = 1'b0;
                    end
                    n_idx = step_idx;
                    if (walk_done) begin
                        n_done  = v ? (r_cnt + CW'(run_len)) : r_cnt;
                        n_state = ST_FINAL;
                    end
                end
            end
            ST_FINAL: begin
                if (slot_free) begin
                    n_out_valid     = 1'b1;
                    n_out_status    = 1'b0;
                    n_out_newly     = 1'b0;
                    n_out_has_range = 1'b0;
                    n_out_start     = '0;
                    n_out_length    = '0;
                    n_out_total     = r_done;
                    n_out_last      = 1'b1;
                    n_state         = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // The read always follows the next block index, so the word is registered together with that index.
    assign rd_addr = word_addr(n_idx);

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        r_word <= mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= ST_CLEAR;
            r_clr_addr    <= '0;
            r_block_count <= rbrt_pkg::BLOCK_COUNT_RST;
            r_pos         <= '0;
            r_done        <= '0;
            r_out_valid   <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr_addr  <= n_clr_addr;
            r_pos       <= n_pos;
            r_done      <= n_done;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                r_block_count <= i_cfg_wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx           <= n_idx;
        r_begin         <= n_begin;
        r_cnt           <= n_cnt;
        r_start         <= n_start;
        r_open          <= n_open;
        r_lim           <= n_lim;
        r_status        <= n_status;
        r_out_status    <= n_out_status;
        r_out_newly     <= n_out_newly;
        r_out_has_range <= n_out_has_range;
        r_out_start     <= n_out_start;
        r_out_length    <= n_out_length;
        r_out_total     <= n_out_total;
        r_out_last      <= n_out_last;
    end

    assign o_out.valid          = r_out_valid;
    assign o_out.status         = r_out_status;
    assign o_out.newly_marked   = r_out_newly;
    assign o_out.has_range      = r_out_has_range;
    assign o_out.range_start    = r_out_start;
    assign o_out.range_length   = r_out_length;
    assign o_out.received_total = r_out_total;
    assign o_out.last           = r_out_last;

    // A run result is never the closing transaction of a request.
    `RBRT_ASSERT_NEVER(a_run_not_last, o_out.valid && o_out.has_range && o_out.last, "run last")
    // Every reported run holds at least one block.
    `RBRT_ASSERT_RST(a_run_nonempty, o_out.valid && o_out.has_range |-> o_out.range_length != '0, "empty run")
    // A scan never reports more runs than it was allowed.
    `RBRT_ASSERT_RST(a_limit_kept, (r_state == ST_SCAN) && emit |-> r_lim != '0, "limit exceeded")

endmodule

`default_nettype wire
